// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge outside reset.
`define CLFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at each rising clock edge, reset included.
`define CLFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/clfr_pkg.sv -----
// Types, constants and helper functions of the content length deframer.
package clfr_pkg;

  localparam int LEN_BITS    = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] PREFIX_LEN = 4'd15;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef logic [LEN_BITS-1:0] len_t;
  typedef logic [LEN_BITS+3:0] len_wide_t;

  typedef enum logic [1:0] {
    MODE_PREFIX,
    MODE_SPACES,
    MODE_DIGITS,
    MODE_IGNORE
  } mode_t;

  typedef enum logic [1:0] {
    KIND_BODY,
    KIND_NO_LENGTH,
    KIND_EMPTY
  } kind_t;

  typedef struct packed {
    logic [7:0] body_byte;
    kind_t      kind;
    logic       last;
  } result_t;

  function automatic logic [7:0] prefix_char(logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "C";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "t";
      4'd4:    c = "e";
      4'd5:    c = "n";
      4'd6:    c = "t";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "e";
      4'd10:   c = "n";
      4'd11:   c = "g";
      4'd12:   c = "t";
      4'd13:   c = "h";
      4'd14:   c = ":";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/clfr_byte_if.sv -----
// Valid/ready channel that carries one raw stream byte per word.
interface clfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ----- hdl/clfr_result_if.sv -----
// Valid/ready channel that carries one deframer result per word.
interface clfr_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output body_byte, output kind, output last, input ready);
  modport sink (input valid, input body_byte, input kind, input last, output ready);
endinterface

// ----- hdl/content_length_deframer_top.sv -----
// Top level of the content length deframer.
// Takes one raw stream byte per cycle and splits the stream into messages: header lines
// ended by CR LF, a blank line, then a body whose length comes from the last valid
// "Content-Length:" line. Each body byte leaves as a kind 0 word (last set on the final
// byte); a header block with no valid length gives one kind 1 word, a zero length one
// kind 2 word. Each result word is written into the result queue and then into the output
// register, whose contents drive the result channel.
// Bytes are taken every cycle while the two-entry result queue has room; the queue
// fills, and the input stalls, only when the sink holds ready low.
module content_length_deframer_top
  import clfr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  clfr_byte_if.sink     stream,
  clfr_result_if.source msg
);

  logic    push;
  result_t push_data;
  logic    full;
  logic    pop;
  result_t pop_data;
  logic    empty;

  clfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  clfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  clfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .msg      (msg)
  );

endmodule

// ----- hdl/clfr_front.sv -----
// Header parser and body counter: classifies each byte and produces at most one result.
`include "assert_macros.svh"

module clfr_front
  import clfr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  clfr_byte_if.sink     stream,
  output logic          push,
  output result_t       push_data,
  input  logic          full
);

  logic       in_body, in_body_next;
  logic       cr_pending, cr_pending_next;
  logic       line_has_content, line_has_content_next;
  mode_t      line_mode, line_mode_next;
  logic [3:0] prefix_pos, prefix_pos_next;
  len_t       digit_accum, digit_accum_next;
  logic       digit_seen, digit_seen_next;
  logic       digit_ovf, digit_ovf_next;
  logic       length_valid, length_valid_next;
  len_t       length_value, length_value_next;
  len_t       body_remaining, body_remaining_next;

  logic       take;
  logic [7:0] b;
  logic       is_digit;
  len_wide_t  scaled;
  len_t       remaining_dec;
  logic [3:0] pos_inc;

  assign stream.ready = !full;
  assign take         = stream.valid && !full;
  assign b            = stream.in_byte;
  assign is_digit     = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign scaled       = ({4'b0, digit_accum} << 3) + ({4'b0, digit_accum} << 1)
                        + len_wide_t'(b[3:0]);
  assign remaining_dec = body_remaining - len_t'(1);
  assign pos_inc       = prefix_pos + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_body          <= 1'b0;
      cr_pending       <= 1'b0;
      line_has_content <= 1'b0;
      line_mode        <= MODE_PREFIX;
      prefix_pos       <= 4'd0;
      digit_accum      <= '0;
      digit_seen       <= 1'b0;
      digit_ovf        <= 1'b0;
      length_valid     <= 1'b0;
      length_value     <= '0;
      body_remaining   <= '0;
    end else begin
      in_body          <= in_body_next;
      cr_pending       <= cr_pending_next;
      line_has_content <= line_has_content_next;
      line_mode        <= line_mode_next;
      prefix_pos       <= prefix_pos_next;
      digit_accum      <= digit_accum_next;
      digit_seen       <= digit_seen_next;
      digit_ovf        <= digit_ovf_next;
      length_valid     <= length_valid_next;
      length_value     <= length_value_next;
      body_remaining   <= body_remaining_next;
    end
  end

  always_comb begin
    in_body_next          = in_body;
    cr_pending_next       = cr_pending;
    line_has_content_next = line_has_content;
    line_mode_next        = line_mode;
    prefix_pos_next       = prefix_pos;
    digit_accum_next      = digit_accum;
    digit_seen_next       = digit_seen;
    digit_ovf_next        = digit_ovf;
    length_valid_next     = length_valid;
    length_value_next     = length_value;
    body_remaining_next   = body_remaining;
    push                  = 1'b0;
    push_data.body_byte   = 8'h00;
    push_data.kind        = KIND_BODY;
    push_data.last        = 1'b1;

    if (take) begin
      if (in_body) begin
        push                = 1'b1;
        push_data.body_byte = b;
        push_data.last      = (remaining_dec == '0);
        body_remaining_next = remaining_dec;
        if (remaining_dec == '0) begin
          in_body_next = 1'b0;
        end
      end else if (cr_pending && b == CHAR_LF) begin
        cr_pending_next       = 1'b0;
        line_has_content_next = 1'b0;
        line_mode_next        = MODE_PREFIX;
        prefix_pos_next       = 4'd0;
        digit_accum_next      = '0;
        digit_seen_next       = 1'b0;
        digit_ovf_next        = 1'b0;
        if (line_has_content) begin
          if (line_mode == MODE_DIGITS && digit_seen && !digit_ovf) begin
            length_valid_next = 1'b1;
            length_value_next = digit_accum;
          end
        end else if (!length_valid) begin
          push           = 1'b1;
          push_data.kind = KIND_NO_LENGTH;
        end else if (length_value == '0) begin
          length_valid_next = 1'b0;
          push              = 1'b1;
          push_data.kind    = KIND_EMPTY;
        end else begin
          in_body_next        = 1'b1;
          body_remaining_next = length_value;
          length_valid_next   = 1'b0;
          length_value_next   = '0;
        end
      end else if (cr_pending) begin
        // lone CR is content that no valid line can hold
        line_has_content_next = 1'b1;
        line_mode_next        = MODE_IGNORE;
        cr_pending_next       = (b == CHAR_CR);
      end else if (b == CHAR_CR) begin
        cr_pending_next = 1'b1;
      end else begin
        line_has_content_next = 1'b1;
        case (line_mode)
          MODE_PREFIX: begin
            if (prefix_pos < PREFIX_LEN && b == prefix_char(prefix_pos)) begin
              prefix_pos_next = pos_inc;
              if (pos_inc == PREFIX_LEN) begin
                line_mode_next = MODE_SPACES;
              end
            end else begin
              line_mode_next = MODE_IGNORE;
            end
          end
          MODE_SPACES, MODE_DIGITS: begin
            if (line_mode == MODE_SPACES && b == CHAR_SPACE) begin
              line_mode_next = MODE_SPACES;
            end else if (is_digit) begin
              line_mode_next  = MODE_DIGITS;
              digit_seen_next = 1'b1;
              if (!digit_ovf) begin
                if (scaled[LEN_BITS+3:LEN_BITS] != 4'd0) begin
                  digit_ovf_next = 1'b1;
                end else begin
                  digit_accum_next = scaled[LEN_BITS-1:0];
                end
              end
            end else begin
              line_mode_next = MODE_IGNORE;
            end
          end
          default: begin
            line_mode_next = MODE_IGNORE;
          end
        endcase
      end
    end
  end

  `CLFR_ASSERT(a_body_len_cleared, in_body |-> !length_valid, "length kept inside body")
  `CLFR_ASSERT(a_body_count_live, in_body |-> (body_remaining != '0), "body with no bytes left")
  `CLFR_ASSERT(a_status_ends_msg, (push && push_data.kind != KIND_BODY) |=> !in_body,
               "status result left parser in body")

endmodule

// ----- hdl/clfr_queue.sv -----
// Short result queue between the parser and the output stage.
`include "assert_macros.svh"

module clfr_queue
  import clfr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  input  logic    pop,
  output result_t pop_data,
  output logic    empty
);

  result_t               entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [CNT_BITS-1:0]   count;

  assign full     = (count == CNT_BITS'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `CLFR_ASSERT(a_no_overflow, full |-> !push, "word pushed into full queue")
  `CLFR_ASSERT(a_no_underflow, empty |-> !pop, "word popped from empty queue")
  `CLFR_ASSERT(a_count_up, (push && !pop) |=> (count == $past(count) + 1'b1),
               "queue count lost a push")

endmodule

// ----- hdl/clfr_back.sv -----
// Output register stage that drains the result queue onto the result channel.
`include "assert_macros.svh"

module clfr_back
  import clfr_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  result_t       pop_data,
  output logic          pop,
  clfr_result_if.source msg
);

  logic    valid_q;
  result_t data_q;

  assign pop           = !empty && (!valid_q || msg.ready);
  assign msg.valid     = valid_q;
  assign msg.body_byte = data_q.body_byte;
  assign msg.kind      = data_q.kind;
  assign msg.last      = data_q.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (pop) begin
      valid_q <= 1'b1;
    end else if (msg.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_q <= pop_data;
    end
  end

  `CLFR_ASSERT(a_fill_idle_stage, (!empty && !valid_q) |=> valid_q,
               "queued word not moved to idle output")
  `CLFR_ASSERT_ALWAYS(a_reset_idle, rst |=> !valid_q, "output valid after reset")

endmodule

// ----- verif/content_length_deframer_top_tb.sv -----
// Self-checking testbench for the content length deframer: random framed streams, scoreboard.
module content_length_deframer_top_tb;
  import clfr_pkg::*;

  localparam int ITEMS       = 950;
  localparam int HOLD_CYCLES = 200;
  localparam int LIMIT       = 500000;
  localparam logic [8*15-1:0] HDR_NAME = "Content-Length:";

  class deframe_scoreboard;
    result_t     expected_q[$];
    int unsigned mismatches;
    int unsigned bytes_in;
    int unsigned body_words;
    int unsigned no_len_words;
    int unsigned empty_words;
    bit          body_mode;
    bit          cr_held;
    bit          line_nonempty;
    bit          len_ok;
    bit          num_seen;
    bit          num_ovf;
    mode_t       scan_mode;
    logic [3:0]  match_len;
    len_t        num_acc;
    len_t        len_val;
    len_t        body_left;

    function new();
      body_mode = 1'b0;
      cr_held   = 1'b0;
      len_ok    = 1'b0;
      len_val   = '0;
      body_left = '0;
      reset_line();
    endfunction

    function void reset_line();
      line_nonempty = 1'b0;
      scan_mode     = MODE_PREFIX;
      match_len     = '0;
      num_acc       = '0;
      num_seen      = 1'b0;
      num_ovf       = 1'b0;
    endfunction

    function void scan_char(logic [7:0] c);
      len_wide_t grown;
      line_nonempty = 1'b1;
      case (scan_mode)
        MODE_PREFIX: begin
          if (match_len < PREFIX_LEN && c == HDR_NAME[8*(14 - match_len) +: 8]) begin
            match_len = match_len + 4'd1;
            if (match_len == PREFIX_LEN) scan_mode = MODE_SPACES;
          end else begin
            scan_mode = MODE_IGNORE;
          end
        end
        MODE_SPACES, MODE_DIGITS: begin
          if (!(scan_mode == MODE_SPACES && c == CHAR_SPACE)) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
              scan_mode = MODE_DIGITS;
              num_seen  = 1'b1;
              if (!num_ovf) begin
                grown = len_wide_t'(num_acc) * 10 + len_wide_t'(c - CHAR_ZERO);
                if (grown[LEN_BITS+3:LEN_BITS] != '0) num_ovf = 1'b1;
                else num_acc = grown[LEN_BITS-1:0];
              end
            end else begin
              scan_mode = MODE_IGNORE;
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      result_t r;
      bytes_in++;
      r.body_byte = '0;
      r.last      = 1'b1;
      if (body_mode) begin
        if (body_left != 0) body_left = body_left - 1'b1;
        r.body_byte = b;
        r.kind      = KIND_BODY;
        r.last      = (body_left == 0);
        expected_q.push_back(r);
        if (body_left == 0) body_mode = 1'b0;
        return;
      end
      if (cr_held) begin
        cr_held = 1'b0;
        if (b == CHAR_LF) begin
          if (line_nonempty) begin
            if (scan_mode == MODE_DIGITS && num_seen && !num_ovf) begin
              len_ok  = 1'b1;
              len_val = num_acc;
            end
            reset_line();
          end else begin
            reset_line();
            if (!len_ok) begin
              r.kind = KIND_NO_LENGTH;
              expected_q.push_back(r);
            end else if (len_val == 0) begin
              len_ok = 1'b0;
              r.kind = KIND_EMPTY;
              expected_q.push_back(r);
            end else begin
              body_mode = 1'b1;
              body_left = len_val;
              len_ok    = 1'b0;
              len_val   = '0;
            end
          end
          return;
        end
        scan_char(CHAR_CR);
      end
      if (b == CHAR_CR) cr_held = 1'b1;
      else scan_char(b);
    endfunction

    function void check_word(logic [7:0] bb, logic [1:0] k, logic l);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word byte=%02h kind=%0d last=%0b", bb, k, l);
        return;
      end
      want = expected_q.pop_front();
      if (bb !== want.body_byte || k !== want.kind || l !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected byte=%02h kind=%0d last=%0b, got byte=%02h kind=%0d last=%0b",
                   want.body_byte, want.kind, want.last, bb, k, l);
      end
      case (want.kind)
        KIND_BODY:      body_words++;
        KIND_NO_LENGTH: no_len_words++;
        default:        empty_words++;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  clfr_byte_if   stream_if ();
  clfr_result_if msg_if ();

  deframe_scoreboard sb = new();
  logic [7:0]  stream_q[$];
  int unsigned cycles;
  int unsigned sent;
  bit          hold_req;
  bit          idle_on;

  content_length_deframer_top u_top (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_if),
    .msg    (msg_if)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycles, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && stream_if.valid && stream_if.ready) sb.note_byte(stream_if.in_byte);
    if (!rst && msg_if.valid && msg_if.ready)
      sb.check_word(msg_if.body_byte, msg_if.kind, msg_if.last);
  end

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
  endtask

  task automatic put_crlf();
    stream_q.push_back(CHAR_CR);
    stream_q.push_back(CHAR_LF);
  endtask

  task automatic put_len_line(string digits, int spaces);
    put_text("Content-Length:");
    repeat (spaces) stream_q.push_back(CHAR_SPACE);
    put_text(digits);
    put_crlf();
  endtask

  task automatic put_body(int n);
    repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r < 16) return $urandom_range(1, 12);
    return $urandom_range(13, 48);
  endfunction

  task automatic put_noise();
    int r;
    repeat ($urandom_range(1, 12)) begin
      r = $urandom_range(0, 5);
      if (r == 0) stream_q.push_back(CHAR_CR);
      else if (r == 1) stream_q.push_back(CHAR_LF);
      else stream_q.push_back(8'($urandom_range(0, 255)));
    end
    put_crlf();
  endtask

  task automatic put_msg();
    int         v;
    int         blen;
    bit         have;
    string      pad;
    string      alt;
    logic [7:0] b;
    have = 1'b0;
    blen = 0;
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: begin
          v   = pick_len();
          pad = "";
          if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) pad = {pad, "0"};
          put_len_line({pad, $sformatf("%0d", v)}, $urandom_range(0, 3));
          have = 1'b1;
          blen = v;
        end
        4: begin
          put_len_line("4294967295", $urandom_range(0, 2));
          v = pick_len();
          put_len_line($sformatf("%0d", v), 1);
          have = 1'b1;
          blen = v;
        end
        5: begin
          if ($urandom_range(0, 1)) alt = "4294967296";
          else alt = "123456789012";
          put_len_line(alt, $urandom_range(0, 2));
        end
        6: put_len_line("", $urandom_range(0, 4));
        7: begin
          if ($urandom_range(0, 1)) alt = "x";
          else alt = " ";
          put_len_line({$sformatf("%0d", pick_len()), alt}, 1);
        end
        8: begin
          if ($urandom_range(0, 1)) alt = "Content-Lengt: 3";
          else alt = "content-Length: 3";
          put_text(alt);
          put_crlf();
        end
        9: begin
          put_text("Content-Length: 2");
          stream_q.push_back(CHAR_CR);
          if ($urandom_range(0, 1)) put_text("5");
          put_crlf();
        end
        10: begin
          put_text("Host: x");
          put_crlf();
        end
        default: begin
          repeat ($urandom_range(1, 10)) begin
            b = 8'($urandom_range(0, 255));
            stream_q.push_back(b == CHAR_CR ? CHAR_LF : b);
          end
          put_crlf();
        end
      endcase
    end
    put_crlf();
    if (have) put_body(blen);
  endtask

  task automatic send_byte(logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      stream_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    stream_if.valid   <= 1'b1;
    stream_if.in_byte <= b;
    do @(posedge clk); while (!stream_if.ready);
    sent++;
  endtask

  task automatic send_all();
    while (stream_q.size() != 0) send_byte(stream_q.pop_front());
  endtask

  initial begin
    msg_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        msg_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        msg_if.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      msg_if.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin
    bit held;
    bit paused;
    held    = 1'b0;
    paused  = 1'b0;
    idle_on = 1'b1;
    stream_if.valid   <= 1'b0;
    stream_if.in_byte <= '0;
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    put_crlf();
    put_len_line("0", 0);
    put_crlf();
    put_len_line("4294967295", 1);
    put_len_line("00", 0);
    put_crlf();
    put_len_line("4", 2);
    put_crlf();
    stream_q.push_back(8'h00);
    stream_q.push_back(8'hFF);
    put_crlf();
    put_len_line("4294967296", 1);
    put_len_line("", 3);
    put_len_line("3x", 0);
    put_crlf();
    put_len_line("1", 0);
    put_text("Content-Length: 2");
    stream_q.push_back(CHAR_CR);
    put_crlf();
    put_crlf();
    put_body(1);
    send_all();

    while (sent < ITEMS) begin
      if ($urandom_range(0, 6) == 0) put_noise();
      else put_msg();
      send_all();
      if (!held && sent >= 300) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (!paused && sent >= 550) begin
        paused = 1'b1;
        stream_if.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      if (sent >= 800) idle_on = 1'b0;
    end
    stream_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Run covered %0d stream bytes: %0d body words, %0d blocks without length, %0d empty",
             sb.bytes_in, sb.body_words, sb.no_len_words, sb.empty_words);
    $display("Edge-case headers, random messages with noise, a long output hold-off, a drain pause");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
